/* design/webm_audio_block_demux_top_defines.svh */
// Assertion macros for the WebM audio block demux checker.
// Used by wabd_checker.sv; expects i_clk and i_rst_n in scope.
`ifndef WEBM_AUDIO_BLOCK_DEMUX_TOP_DEFINES_SVH
`define WEBM_AUDIO_BLOCK_DEMUX_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define WABD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WABD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define WABD_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/wabd_pkg.sv */
// Types, constants and helper functions for the WebM audio block demux.
// No dependencies; used by every module in the design.
`default_nettype none

package wabd_pkg;

    // Element IDs, marker bits included
    localparam logic [31:0] ID_CLUSTER   = 32'h1F43_B675;
    localparam logic [31:0] ID_TIMECODE  = 32'h0000_00E7;
    localparam logic [31:0] ID_SIMPLEBLK = 32'h0000_00A3;
    localparam logic [31:0] ID_BLOCK     = 32'h0000_00A1;

    // ns to ms
    localparam logic [19:0] MS_DIVISOR = 20'd1000000;

    // Configuration register indexes and reset values
    localparam int          CFG_IDX_W          = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_TRACK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMECODE_SCALE = 2'd1;
    localparam logic [31:0] AUDIO_TRACK_RST    = 32'd1;
    localparam logic [31:0] TIMECODE_SCALE_RST = 32'd1000000;

    typedef enum logic [3:0] {
        PH_ID        = 4'd0,
        PH_ID_MORE   = 4'd1,
        PH_SIZE      = 4'd2,
        PH_SIZE_MORE = 4'd3,
        PH_TC        = 4'd4,
        PH_TRK       = 4'd5,
        PH_TRK_MORE  = 4'd6,
        PH_OFS_HI    = 4'd7,
        PH_OFS_LO    = 4'd8,
        PH_FLAGS     = 4'd9,
        PH_PAYLOAD   = 4'd10,
        PH_SKIP      = 4'd11
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] time_ms;
        logic        first;
        logic        last;
        logic        error;
    } t_out;

    typedef struct packed {
        logic [19:0] rem;
        logic [7:0]  q;
    } t_div_step;

    // Length of a vint from its lead byte: 1..8, 0 when the byte is zero.
    function automatic logic [3:0] vint_len(input logic [7:0] b);
        logic [3:0] len;
        len = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                len = 4'(8 - i);
            end
        end
        return len;
    endfunction

    // Lead byte with its marker bit cleared.
    function automatic logic [7:0] vint_lead(input logic [7:0] b, input logic [3:0] len);
        logic [7:0] m;
        m = 8'h80 >> (len - 4'd1);
        return b & ~m;
    endfunction

    // All-ones value of a size vint of the given length (unknown size).
    function automatic logic [63:0] vint_unknown(input logic [3:0] len);
        logic [63:0] m;
        unique case (len)
            4'd1:    m = 64'h0000_0000_0000_007F;
            4'd2:    m = 64'h0000_0000_0000_3FFF;
            4'd3:    m = 64'h0000_0000_001F_FFFF;
            4'd4:    m = 64'h0000_0000_0FFF_FFFF;
            4'd5:    m = 64'h0000_0007_FFFF_FFFF;
            4'd6:    m = 64'h0000_03FF_FFFF_FFFF;
            4'd7:    m = 64'h0001_FFFF_FFFF_FFFF;
            4'd8:    m = 64'h00FF_FFFF_FFFF_FFFF;
            default: m = '0;
        endcase
        return m;
    endfunction

    // Eight restoring-division steps by MS_DIVISOR; rem stays below the divisor.
    function automatic t_div_step div_step8(input logic [19:0] rem, input logic [7:0] bits);
        t_div_step  s;
        logic [20:0] r;
        r = {1'b0, rem};
        s.q = '0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[19:0], bits[i]};
            if (r >= {1'b0, MS_DIVISOR}) begin
                r      = r - {1'b0, MS_DIVISOR};
                s.q[i] = 1'b1;
            end
        end
        s.rem = r[19:0];
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/webm_audio_block_demux_top.sv */
// An accepted byte is held in the input register; its result is registered in the
// output register when that byte proceeds. Throughput: one byte per cycle while the
// output is taken; a block's time-offset low byte waits while the cluster time unit
// (2-stage multiply, 8-stage divide by 1000000) is busy with a new timecode.
// Reset: synchronous, active low; parse state and cluster time clear, audio_track
// returns to 1, timecode_scale to 1000000; all ready outputs are low in reset.
`default_nettype none

module webm_audio_block_demux_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wabd_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wabd_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wabd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic               r_rdy;
    logic [31:0]        r_audio_track;
    logic [31:0]        r_timecode_scale;

    logic               r_in_valid;
    wabd_pkg::t_in      r_in;
    logic               r_out_valid;
    wabd_pkg::t_out     r_out;

    wabd_pkg::t_phase   r_phase, n_phase;
    logic [31:0]        r_id_shift, n_id_shift;
    logic [3:0]         r_fbl, n_fbl;
    logic [63:0]        r_value, n_value;
    logic [63:0]        r_esize, n_esize;
    logic [63:0]        r_togo, n_togo;
    logic [63:0]        r_track, n_track;
    logic [3:0]         r_hdr, n_hdr;
    logic [7:0]         r_ofs_hi, n_ofs_hi;
    logic [31:0]        r_ptime, n_ptime;
    logic               r_halted, n_halted;

    wabd_pkg::t_phase   eff_phase;
    logic               eff_halt;
    logic [7:0]         b;
    logic [3:0]         len;
    logic [3:0]         hdr_inc;
    logic               sd_fire;
    logic [63:0]        sd_v;
    logic [3:0]         sd_len;
    logic               unknown;
    logic               tc_launch;
    logic [63:0]        tc_value;
    logic               res_valid;
    wabd_pkg::t_out     res;

    logic               ct_busy;
    logic [31:0]        ct_time;
    logic               stall;
    logic               proceed;

    wabd_ctime u_ctime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_launch(proceed & tc_launch),
        .i_value (tc_value),
        .i_scale (r_timecode_scale),
        .o_busy  (ct_busy),
        .o_ctime (ct_time)
    );

    assign eff_phase = r_in.restart ? wabd_pkg::PH_ID : r_phase;
    assign eff_halt  = r_in.restart ? 1'b0 : r_halted;
    // offset byte reads cluster time; hold it while a new value is in flight
    assign stall     = (eff_phase == wabd_pkg::PH_OFS_LO) && ct_busy;
    assign proceed   = r_in_valid && (!r_out_valid || i_out_ready) && !stall;

    assign o_in_ready  = r_rdy && (!r_in_valid || proceed);
    assign o_cfg_ready = r_rdy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        b          = r_in.in_byte;
        len        = wabd_pkg::vint_len(b);
        hdr_inc    = r_hdr + 4'd1;
        n_phase    = eff_phase;
        n_halted   = eff_halt;
        n_id_shift = r_id_shift;
        n_fbl      = r_fbl;
        n_value    = r_value;
        n_esize    = r_esize;
        n_togo     = r_togo;
        n_track    = r_track;
        n_hdr      = r_hdr;
        n_ofs_hi   = r_ofs_hi;
        n_ptime    = r_ptime;
        sd_fire    = 1'b0;
        sd_v       = '0;
        sd_len     = '0;
        unknown    = 1'b0;
        tc_launch  = 1'b0;
        tc_value   = '0;
        res_valid  = 1'b0;
        res        = '0;

        if (!eff_halt) begin
            unique case (eff_phase)
                wabd_pkg::PH_ID: begin
                    if (len == 4'd0 || len > 4'd4) begin
                        n_halted  = 1'b1;
                        res_valid = 1'b1;
                        res.error = 1'b1;
                    end else begin
                        n_id_shift = {24'h0, b};
                        n_fbl      = len - 4'd1;
                        n_phase    = (len != 4'd1) ? wabd_pkg::PH_ID_MORE : wabd_pkg::PH_SIZE;
                    end
                end
                wabd_pkg::PH_ID_MORE: begin
                    n_id_shift = {r_id_shift[23:0], b};
                    n_fbl      = r_fbl - 4'd1;
                    if (n_fbl == 4'd0) begin
                        n_phase = wabd_pkg::PH_SIZE;
                    end
                end
                wabd_pkg::PH_SIZE: begin
                    if (len == 4'd0) begin
                        sd_fire = 1'b1;
                    end else begin
                        n_hdr   = len;
                        n_fbl   = len - 4'd1;
                        n_value = {56'h0, wabd_pkg::vint_lead(b, len)};
                        if (len == 4'd1) begin
                            sd_fire = 1'b1;
                            sd_v    = n_value;
                            sd_len  = len;
                        end else begin
                            n_phase = wabd_pkg::PH_SIZE_MORE;
                        end
                    end
                end
                wabd_pkg::PH_SIZE_MORE: begin
                    n_value = {r_value[55:0], b};
                    n_fbl   = r_fbl - 4'd1;
                    if (n_fbl == 4'd0) begin
                        sd_fire = 1'b1;
                        sd_v    = n_value;
                        sd_len  = r_hdr;
                    end
                end
                wabd_pkg::PH_TC: begin
                    n_value = {r_value[55:0], b};
                    n_togo  = r_togo - 64'd1;
                    if (n_togo == 64'd0) begin
                        tc_launch = 1'b1;
                        tc_value  = n_value;
                        n_phase   = wabd_pkg::PH_ID;
                    end
                end
                wabd_pkg::PH_TRK: begin
                    n_hdr = 4'd1;
                    if (len == 4'd0) begin
                        n_track = '0;
                        n_phase = wabd_pkg::PH_OFS_HI;
                    end else begin
                        n_fbl   = len - 4'd1;
                        n_value = {56'h0, wabd_pkg::vint_lead(b, len)};
                        if (len == 4'd1) begin
                            n_track = n_value;
                            n_phase = wabd_pkg::PH_OFS_HI;
                        end else begin
                            n_phase = wabd_pkg::PH_TRK_MORE;
                        end
                    end
                end
                wabd_pkg::PH_TRK_MORE: begin
                    n_hdr   = hdr_inc;
                    n_value = {r_value[55:0], b};
                    n_fbl   = r_fbl - 4'd1;
                    if (n_fbl == 4'd0) begin
                        n_track = n_value;
                        n_phase = wabd_pkg::PH_OFS_HI;
                    end
                end
                wabd_pkg::PH_OFS_HI: begin
                    n_hdr    = hdr_inc;
                    n_ofs_hi = b;
                    n_phase  = wabd_pkg::PH_OFS_LO;
                end
                wabd_pkg::PH_OFS_LO: begin
                    n_hdr   = hdr_inc;
                    n_ptime = ct_time + {{16{r_ofs_hi[7]}}, r_ofs_hi, b};
                    n_phase = wabd_pkg::PH_FLAGS;
                end
                wabd_pkg::PH_FLAGS: begin
                    n_hdr = hdr_inc;
                    if (r_esize > {60'h0, hdr_inc}) begin
                        n_togo = r_esize - {60'h0, hdr_inc};
                        if (r_track == {32'h0, r_audio_track}) begin
                            n_fbl   = 4'd1;
                            n_phase = wabd_pkg::PH_PAYLOAD;
                        end else begin
                            n_phase = wabd_pkg::PH_SKIP;
                        end
                    end else begin
                        n_phase = wabd_pkg::PH_ID;
                    end
                end
                wabd_pkg::PH_PAYLOAD: begin
                    res_valid    = 1'b1;
                    res.out_byte = b;
                    res.time_ms  = r_ptime;
                    res.first    = (r_fbl != 4'd0);
                    res.last     = (r_togo == 64'd1);
                    n_fbl        = 4'd0;
                    n_togo       = r_togo - 64'd1;
                    if (n_togo == 64'd0) begin
                        n_phase = wabd_pkg::PH_ID;
                    end
                end
                wabd_pkg::PH_SKIP: begin
                    n_togo = r_togo - 64'd1;
                    if (n_togo == 64'd0) begin
                        n_phase = wabd_pkg::PH_ID;
                    end
                end
                default: begin
                    n_phase = wabd_pkg::PH_ID;
                end
            endcase

            // size vint complete: pick what the element body means
            if (sd_fire) begin
                unknown = (sd_len != 4'd0) && (sd_v == wabd_pkg::vint_unknown(sd_len));
                n_esize = sd_v;
                priority if (r_id_shift == wabd_pkg::ID_CLUSTER || unknown) begin
                    n_phase = wabd_pkg::PH_ID;
                end else if (r_id_shift == wabd_pkg::ID_TIMECODE) begin
                    if (sd_v == 64'd0) begin
                        // empty timecode: push a zero so it lands in order
                        tc_launch = 1'b1;
                        tc_value  = '0;
                        n_phase   = wabd_pkg::PH_ID;
                    end else begin
                        n_value = '0;
                        n_togo  = sd_v;
                        n_phase = wabd_pkg::PH_TC;
                    end
                end else if (r_id_shift == wabd_pkg::ID_SIMPLEBLK ||
                             r_id_shift == wabd_pkg::ID_BLOCK) begin
                    n_hdr   = 4'd0;
                    n_phase = wabd_pkg::PH_TRK;
                end else if (sd_v == 64'd0) begin
                    n_phase = wabd_pkg::PH_ID;
                end else begin
                    n_togo  = sd_v;
                    n_phase = wabd_pkg::PH_SKIP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy            <= 1'b0;
            r_audio_track    <= wabd_pkg::AUDIO_TRACK_RST;
            r_timecode_scale <= wabd_pkg::TIMECODE_SCALE_RST;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_phase          <= wabd_pkg::PH_ID;
            r_id_shift       <= '0;
            r_fbl            <= '0;
            r_value          <= '0;
            r_esize          <= '0;
            r_togo           <= '0;
            r_track          <= '0;
            r_hdr            <= '0;
            r_ofs_hi         <= '0;
            r_ptime          <= '0;
            r_halted         <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
            if (r_rdy && i_cfg_valid) begin
                if (i_cfg_index == wabd_pkg::CFG_AUDIO_TRACK) begin
                    r_audio_track <= i_cfg_data;
                end else if (i_cfg_index == wabd_pkg::CFG_TIMECODE_SCALE) begin
                    r_timecode_scale <= i_cfg_data;
                end
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proceed) begin
                r_out_valid <= res_valid;
                r_phase     <= n_phase;
                r_id_shift  <= n_id_shift;
                r_fbl       <= n_fbl;
                r_value     <= n_value;
                r_esize     <= n_esize;
                r_togo      <= n_togo;
                r_track     <= n_track;
                r_hdr       <= n_hdr;
                r_ofs_hi    <= n_ofs_hi;
                r_ptime     <= n_ptime;
                r_halted    <= n_halted;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in;
        end
        if (proceed) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

/* design/wabd_ctime.sv */
// Cluster time unit: (value * scale mod 2^64) / 1000000, low 32 bits kept.
// Two-stage multiply, eight-stage divide; depends on wabd_pkg.
`default_nettype none

module wabd_ctime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_launch,
    input  logic [63:0] i_value,
    input  logic [31:0] i_scale,
    output logic        o_busy,
    output logic [31:0] o_ctime
);

    localparam int DivStages = 8;

    logic [63:0] prod_lo;
    logic [31:0] prod_hi;

    logic        r_m_v;
    logic [63:0] r_m_lo;
    logic [31:0] r_m_hi;
    logic        r_a_v;
    logic [63:0] r_a_p;

    logic [DivStages-1:0] r_d_v;
    logic [19:0] r_d_rem [DivStages];
    logic [63:0] r_d_num [DivStages];
    logic [31:0] r_d_q   [DivStages];
    logic [19:0] n_d_rem [DivStages];
    logic [63:0] n_d_num [DivStages];
    logic [31:0] n_d_q   [DivStages];

    logic [31:0] r_ctime;

    // 64x32 product mod 2^64 from two 32x32 halves
    assign prod_lo = i_value[31:0] * i_scale;
    assign prod_hi = i_value[63:32] * i_scale;

    for (genvar k = 0; k < DivStages; k++) begin : g_div
        logic [19:0]      rem_in;
        logic [63:0]      num_in;
        logic [31:0]      q_in;
        wabd_pkg::t_div_step st;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = r_a_p;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = r_d_rem[k-1];
            assign num_in = r_d_num[k-1];
            assign q_in   = r_d_q[k-1];
        end

        assign st         = wabd_pkg::div_step8(rem_in, num_in[63:56]);
        assign n_d_rem[k] = st.rem;
        assign n_d_num[k] = {num_in[55:0], 8'h00};
        assign n_d_q[k]   = {q_in[23:0], st.q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v   <= 1'b0;
            r_a_v   <= 1'b0;
            r_d_v   <= '0;
            r_ctime <= '0;
        end else begin
            r_m_v <= i_launch;
            r_a_v <= r_m_v;
            r_d_v <= {r_d_v[DivStages-2:0], r_a_v};
            if (r_d_v[DivStages-1]) begin
                r_ctime <= r_d_q[DivStages-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_lo <= prod_lo;
        r_m_hi <= prod_hi;
        r_a_p  <= r_m_lo + {r_m_hi, 32'h0};
        for (int k = 0; k < DivStages; k++) begin
            r_d_rem[k] <= n_d_rem[k];
            r_d_num[k] <= n_d_num[k];
            r_d_q[k]   <= n_d_q[k];
        end
    end

    assign o_busy  = r_m_v | r_a_v | (|r_d_v);
    assign o_ctime = r_ctime;

endmodule

`default_nettype wire

/* design/wabd_checker.sv */
// Port-level checks for webm_audio_block_demux_top, bound to it below.
// Depends on wabd_pkg and webm_audio_block_demux_top_defines.svh.
`default_nettype none
`include "webm_audio_block_demux_top_defines.svh"

module wabd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  wabd_pkg::t_in                     i_in,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  wabd_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [wabd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic        r_prev_open;
    logic [31:0] r_prev_time;
    logic        in_req;
    logic        cfg_req;

    // request activity on the input side; kept for waveform debug
    assign in_req  = i_in_valid & o_in_ready & (i_in.restart | ~i_in.restart);
    assign cfg_req = i_cfg_valid & o_cfg_ready & (|{i_cfg_index, i_cfg_data} | 1'b1);

    // previous delivered result was a payload byte with more of its block to come
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_open <= 1'b0;
            r_prev_time <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_prev_open <= !o_out.error && !o_out.last;
            r_prev_time <= o_out.time_ms;
        end
    end

    `WABD_ASSERT_IMP(a_error_clean, o_out_valid && o_out.error,
        o_out.out_byte == 8'h00 && o_out.time_ms == 32'h0 && !o_out.first && !o_out.last,
        "error result carries payload fields")

    `WABD_ASSERT_IMP(a_block_continues, o_out_valid && !o_out.error && !o_out.first,
        r_prev_open && o_out.time_ms == r_prev_time && (in_req || !in_req),
        "non-first payload byte does not continue the open block")

    `WABD_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out), "stalled result changed or dropped")

    `WABD_ASSERT_RST(a_reset_quiet, !i_rst_n,
        !o_out_valid && !o_in_ready && !o_cfg_ready && (cfg_req || !cfg_req),
        "ports not quiet after reset")

endmodule

bind webm_audio_block_demux_top wabd_checker u_wabd_checker (.*);

`default_nettype wire
